### hw/rtl/cib_pkg.sv
// ----------------------------------------------------------------------------
// cib_pkg
// Shared constants, types and small calendar helpers for the calendar interval
// bounds unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cib_pkg;

  localparam int TS_W   = 48;
  localparam int DAY_W  = 22;
  localparam int RDAY_W = 27;
  localparam int OUT_W  = 64;
  localparam int DOE_W  = 18;
  localparam int YOE_W  = 9;

  localparam logic [TS_W-1:0] MS_PER_MIN  = 48'd60000;
  localparam logic [TS_W-1:0] MS_PER_HALF = 48'd1800000;
  localparam logic [TS_W-1:0] MS_PER_HOUR = 48'd3600000;
  localparam logic [TS_W-1:0] MS_PER_DAY  = 48'd86400000;

  // shift from 1970-01-01 to 0000-03-01 in days
  localparam logic [DAY_W-1:0] EPOCH_SHIFT  = 22'd719468;
  localparam logic [DAY_W-1:0] DAYS_PER_ERA = 22'd146097;
  localparam logic [DOE_W-1:0] DAYS_4Y      = 18'd1460;
  localparam logic [DOE_W-1:0] DAYS_100Y    = 18'd36524;
  localparam logic [DOE_W-1:0] DAYS_ERA_M1  = 18'd146096;
  localparam logic [DOE_W-1:0] DAYS_YEAR    = 18'd365;
  localparam logic [10:0]      MP_DIV       = 11'd153;
  localparam logic [DAY_W-1:0] MAR_TO_JAN   = 22'd306;
  localparam logic [DAY_W-1:0] JAN_TO_MAR   = 22'd59;

  typedef enum logic [2:0] {
    PER_MINUTE  = 3'd0,
    PER_HALF    = 3'd1,
    PER_HOUR    = 3'd2,
    PER_DAY     = 3'd3,
    PER_WEEK    = 3'd4,
    PER_MONTH   = 3'd5,
    PER_YEAR    = 3'd6,
    PER_UNKNOWN = 3'd7
  } period_t;

  typedef struct packed {
    logic            vld;
    logic [TS_W-1:0] t;
    period_t         per;
  } cib_item_t;

  typedef struct packed {
    logic              vld;
    logic [TS_W-1:0]   t;
    period_t           per;
    logic [DAY_W-1:0]  day;
    logic [RDAY_W-1:0] rem;
  } cib_day_t;

  typedef struct packed {
    logic              vld;
    logic [TS_W-1:0]   t;
    period_t           per;
    logic [RDAY_W-1:0] rsel;
    logic [DAY_W-1:0]  sday;
    logic [DAY_W-1:0]  eday;
    logic              sneg;
  } cib_bounds_t;

  // first day of month mp (0 = March) counted from March 1
  function automatic logic [8:0] month_off(input logic [3:0] mp);
    logic [8:0] o;
    unique case (mp)
      4'd0:    o = 9'd0;
      4'd1:    o = 9'd31;
      4'd2:    o = 9'd61;
      4'd3:    o = 9'd92;
      4'd4:    o = 9'd122;
      4'd5:    o = 9'd153;
      4'd6:    o = 9'd184;
      4'd7:    o = 9'd214;
      4'd8:    o = 9'd245;
      4'd9:    o = 9'd275;
      4'd10:   o = 9'd306;
      4'd11:   o = 9'd337;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mp, input logic leap);
    logic [4:0] l;
    unique case (mp)
      4'd1, 4'd3, 4'd6, 4'd8: l = 5'd30;
      4'd11:                  l = leap ? 5'd29 : 5'd28;
      default:                l = 5'd31;
    endcase
    return l;
  endfunction

  // leap test on a year taken within its 400-year era (0 counts as 400)
  function automatic logic leap_yoe(input logic [YOE_W-1:0] v);
    return (v[1:0] == 2'd0) && (v != 9'd100) && (v != 9'd200) && (v != 9'd300);
  endfunction

  // mod 7 by octal digit sums (8 == 1 mod 7)
  function automatic logic [2:0] mod7(input logic [DAY_W:0] v);
    logic [23:0] w;
    logic [5:0]  s;
    logic [3:0]  s2;
    w = {1'b0, v};
    s = '0;
    for (int k = 0; k < 8; k++) begin
      s = s + 6'(w[3*k +: 3]);
    end
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    if (s2 >= 4'd7) s2 = s2 - 4'd7;
    if (s2 >= 4'd7) s2 = s2 - 4'd7;
    return s2[2:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cib_if.sv
// ----------------------------------------------------------------------------
// cib_if
// Valid/ready channels of the calendar interval bounds unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface cib_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] timestamp_ms;
  logic [2:0]  period;
  modport source (output valid, timestamp_ms, period, input ready);
  modport sink   (input valid, timestamp_ms, period, output ready);
endinterface

interface cib_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] interval_start;
  logic [63:0] interval_end;
  logic        valid_res;
  modport source (output valid, interval_start, interval_end, valid_res, input ready);
  modport sink   (input valid, interval_start, interval_end, valid_res, output ready);
endinterface

`default_nettype wire

### hw/rtl/calendar_interval_bounds_unit.sv
// ----------------------------------------------------------------------------
// calendar_interval_bounds_unit
// First and last millisecond of the minute, half hour, hour, day, week,
// month or year that holds a UTC millisecond timestamp.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the pipe advances and returns one result word
// per input word, in order. The pipeline holds four stages of the restoring
// divide by one day, five calendar stages (weekday, year of era, month) and one
// stage with the day-to-millisecond multipliers that also serves as the output
// register. The whole pipe advances when the output register is empty or being
// taken, so item.ready follows result.ready in the same cycle. Weeks start on
// Monday; a week start before the epoch is reported as 0. Period code 7 returns
// all ones with valid_res low.
`default_nettype none

module calendar_interval_bounds_unit (
  input  logic             clk,
  input  logic             rst,
  cib_in_if.sink           item,
  cib_out_if.source        result
);

  logic                   adv;
  cib_pkg::cib_item_t     din;
  cib_pkg::cib_day_t      dsplit;
  cib_pkg::cib_bounds_t   bnd;

  logic                          res_vld;
  logic [cib_pkg::OUT_W-1:0]     res_start;
  logic [cib_pkg::OUT_W-1:0]     res_end;
  logic                          res_ok;

  assign adv        = !res_vld || result.ready;
  assign item.ready = adv;

  assign din.vld = item.valid;
  assign din.t   = item.timestamp_ms;
  assign din.per = cib_pkg::period_t'(item.period);

  cib_day_split u_split (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .din  (din),
    .dout (dsplit)
  );

  cib_calendar u_cal (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .din  (dsplit),
    .dout (bnd)
  );

  logic [cib_pkg::OUT_W-1:0] sub_start;
  logic [48:0]               ps;
  logic [48:0]               pe;
  logic [cib_pkg::OUT_W-1:0] start_next;
  logic [cib_pkg::OUT_W-1:0] end_next;
  logic                      ok_next;

  always_comb begin
    sub_start = 64'(bnd.t) - 64'(bnd.rsel);
    ps = 49'(bnd.sday) * 49'(cib_pkg::MS_PER_DAY[cib_pkg::RDAY_W-1:0]);
    pe = 49'(bnd.eday) * 49'(cib_pkg::MS_PER_DAY[cib_pkg::RDAY_W-1:0]);
    ok_next = 1'b1;
    unique case (bnd.per)
      cib_pkg::PER_MINUTE: begin
        start_next = sub_start;
        end_next   = sub_start + 64'(cib_pkg::MS_PER_MIN - 48'd1);
      end
      cib_pkg::PER_HALF: begin
        start_next = sub_start;
        end_next   = sub_start + 64'(cib_pkg::MS_PER_HALF - 48'd1);
      end
      cib_pkg::PER_HOUR: begin
        start_next = sub_start;
        end_next   = sub_start + 64'(cib_pkg::MS_PER_HOUR - 48'd1);
      end
      cib_pkg::PER_DAY: begin
        start_next = sub_start;
        end_next   = sub_start + 64'(cib_pkg::MS_PER_DAY - 48'd1);
      end
      cib_pkg::PER_WEEK, cib_pkg::PER_MONTH, cib_pkg::PER_YEAR: begin
        start_next = bnd.sneg ? '0 : 64'(ps);
        end_next   = 64'(pe) - 64'd1;
      end
      cib_pkg::PER_UNKNOWN: begin
        start_next = '1;
        end_next   = '1;
        ok_next    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= bnd.vld;
    end
    if (adv) begin
      res_start <= start_next;
      res_end   <= end_next;
      res_ok    <= ok_next;
    end
  end

  assign result.valid          = res_vld;
  assign result.interval_start = res_start;
  assign result.interval_end   = res_end;
  assign result.valid_res      = res_ok;

`ifndef SYNTHESIS
  a_unknown_ones: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.valid_res) |->
      (result.interval_start == '1 && result.interval_end == '1))
    else $error("unknown period without all-ones bounds");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.valid_res) |->
      (result.interval_end >= result.interval_start))
    else $error("interval end before start");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

### hw/rtl/cib_day_split.sv
// ----------------------------------------------------------------------------
// cib_day_split
// Four-stage restoring divide of the timestamp by one day: day number and
// millisecond of day.
// ----------------------------------------------------------------------------
`default_nettype none

module cib_day_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  cib_pkg::cib_item_t   din,
  output cib_pkg::cib_day_t    dout
);

  localparam int NST = 4;
  localparam int HI  [NST] = '{21, 15, 9, 4};
  localparam int CNT [NST] = '{6, 6, 5, 5};

  logic                         vld [NST+1];
  logic [cib_pkg::TS_W-1:0]     t   [NST+1];
  cib_pkg::period_t             per [NST+1];
  logic [cib_pkg::TS_W-1:0]     r   [NST+1];
  logic [cib_pkg::DAY_W-1:0]    q   [NST+1];

  assign vld[0] = din.vld;
  assign t[0]   = din.t;
  assign per[0] = din.per;
  assign r[0]   = din.t;
  assign q[0]   = '0;

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [cib_pkg::TS_W-1:0]  r_next;
    logic [cib_pkg::DAY_W-1:0] q_next;

    always_comb begin
      r_next = r[s];
      q_next = q[s];
      for (int k = 0; k < CNT[s]; k++) begin
        if (r_next >= (cib_pkg::MS_PER_DAY << (HI[s] - k))) begin
          r_next = r_next - (cib_pkg::MS_PER_DAY << (HI[s] - k));
          q_next[HI[s] - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        t[s+1]   <= t[s];
        per[s+1] <= per[s];
        r[s+1]   <= r_next;
        q[s+1]   <= q_next;
      end
    end
  end

  assign dout.vld = vld[NST];
  assign dout.t   = t[NST];
  assign dout.per = per[NST];
  assign dout.day = q[NST];
  assign dout.rem = r[NST][cib_pkg::RDAY_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/cib_calendar.sv
// ----------------------------------------------------------------------------
// cib_calendar
// Five-stage calendar pipe: sub-day remainders, day of week, civil year and
// month of the day number, then the first and one-past-last day of the
// selected interval.
// ----------------------------------------------------------------------------
`default_nettype none

module cib_calendar (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  cib_pkg::cib_day_t     din,
  output cib_pkg::cib_bounds_t  dout
);

  // ---------------- stage 1: half hour, weekday, day of era
  logic                          c1_vld;
  logic [cib_pkg::TS_W-1:0]      c1_t;
  cib_pkg::period_t              c1_per;
  logic [cib_pkg::DAY_W-1:0]     c1_day;
  logic [cib_pkg::RDAY_W-1:0]    c1_rday;
  logic                          c1_half0;
  logic [20:0]                   c1_mih;
  logic [2:0]                    c1_dow;
  logic [cib_pkg::DOE_W-1:0]     c1_doe;

  logic [27:0]                   hr;
  logic [5:0]                    hq;
  logic [cib_pkg::DAY_W-1:0]     er;

  always_comb begin
    hr = 28'(din.rem);
    hq = '0;
    for (int k = 0; k < 6; k++) begin
      if (hr >= (28'(cib_pkg::MS_PER_HALF) << (5 - k))) begin
        hr = hr - (28'(cib_pkg::MS_PER_HALF) << (5 - k));
        hq[5 - k] = 1'b1;
      end
    end
    er = din.day + cib_pkg::EPOCH_SHIFT;
    for (int k = 0; k < 5; k++) begin
      if (er >= (cib_pkg::DAYS_PER_ERA << (4 - k))) begin
        er = er - (cib_pkg::DAYS_PER_ERA << (4 - k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
    end else if (adv) begin
      c1_vld <= din.vld;
    end
    if (adv) begin
      c1_t     <= din.t;
      c1_per   <= din.per;
      c1_day   <= din.day;
      c1_rday  <= din.rem;
      c1_half0 <= hq[0];
      c1_mih   <= hr[20:0];
      c1_dow   <= cib_pkg::mod7({1'b0, din.day} + 23'd3);  // Monday = 0
      c1_doe   <= er[cib_pkg::DOE_W-1:0];
    end
  end

  // ---------------- stage 2: minute, remainder select, week, year estimate
  logic                          c2_vld;
  logic [cib_pkg::TS_W-1:0]      c2_t;
  cib_pkg::period_t              c2_per;
  logic [cib_pkg::DAY_W-1:0]     c2_day;
  logic [cib_pkg::DOE_W-1:0]     c2_doe;
  logic [cib_pkg::DOE_W-1:0]     c2_yn;
  logic [cib_pkg::RDAY_W-1:0]    c2_rsel;
  logic [cib_pkg::DAY_W-1:0]     c2_wstart;
  logic [cib_pkg::DAY_W-1:0]     c2_wend;
  logic                          c2_wneg;

  logic [20:0]                   mr;
  logic [21:0]                   rhour;
  logic [cib_pkg::RDAY_W-1:0]    rsel;
  logic [cib_pkg::DOE_W-1:0]     ar;
  logic [6:0]                    aq;
  logic [cib_pkg::DOE_W-1:0]     br;
  logic [2:0]                    bq;

  always_comb begin
    mr = c1_mih;
    for (int k = 0; k < 5; k++) begin
      if (mr >= (21'(cib_pkg::MS_PER_MIN) << (4 - k))) begin
        mr = mr - (21'(cib_pkg::MS_PER_MIN) << (4 - k));
      end
    end
    rhour = 22'(c1_mih) + (c1_half0 ? 22'(cib_pkg::MS_PER_HALF) : 22'd0);
    unique case (c1_per)
      cib_pkg::PER_MINUTE: rsel = 27'(mr);
      cib_pkg::PER_HALF:   rsel = 27'(c1_mih);
      cib_pkg::PER_HOUR:   rsel = 27'(rhour);
      default:             rsel = c1_rday;
    endcase
    ar = c1_doe;
    aq = '0;
    for (int k = 0; k < 7; k++) begin
      if (ar >= (cib_pkg::DAYS_4Y << (6 - k))) begin
        ar = ar - (cib_pkg::DAYS_4Y << (6 - k));
        aq[6 - k] = 1'b1;
      end
    end
    br = c1_doe;
    bq = '0;
    for (int k = 0; k < 3; k++) begin
      if (br >= (cib_pkg::DAYS_100Y << (2 - k))) begin
        br = br - (cib_pkg::DAYS_100Y << (2 - k));
        bq[2 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_vld <= 1'b0;
    end else if (adv) begin
      c2_vld <= c1_vld;
    end
    if (adv) begin
      c2_t      <= c1_t;
      c2_per    <= c1_per;
      c2_day    <= c1_day;
      c2_doe    <= c1_doe;
      c2_yn     <= c1_doe - 18'(aq) + 18'(bq) - 18'(c1_doe == cib_pkg::DAYS_ERA_M1);
      c2_rsel   <= rsel;
      c2_wneg   <= c1_day < 22'(c1_dow);
      c2_wstart <= c1_day - 22'(c1_dow);
      c2_wend   <= c1_day + 22'(3'd7 - c1_dow);
    end
  end

  // ---------------- stage 3: year of era, upper quotient bits
  logic                          c3_vld;
  logic [cib_pkg::TS_W-1:0]      c3_t;
  cib_pkg::period_t              c3_per;
  logic [cib_pkg::DAY_W-1:0]     c3_day;
  logic [cib_pkg::DOE_W-1:0]     c3_doe;
  logic [cib_pkg::DOE_W-1:0]     c3_yr;
  logic [cib_pkg::YOE_W-1:0]     c3_yq;
  logic [cib_pkg::RDAY_W-1:0]    c3_rsel;
  logic [cib_pkg::DAY_W-1:0]     c3_wstart;
  logic [cib_pkg::DAY_W-1:0]     c3_wend;
  logic                          c3_wneg;

  logic [cib_pkg::DOE_W-1:0]     yr3;
  logic [cib_pkg::YOE_W-1:0]     yq3;

  always_comb begin
    yr3 = c2_yn;
    yq3 = '0;
    for (int k = 0; k < 5; k++) begin
      if (yr3 >= (cib_pkg::DAYS_YEAR << (8 - k))) begin
        yr3 = yr3 - (cib_pkg::DAYS_YEAR << (8 - k));
        yq3[8 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_vld <= 1'b0;
    end else if (adv) begin
      c3_vld <= c2_vld;
    end
    if (adv) begin
      c3_t      <= c2_t;
      c3_per    <= c2_per;
      c3_day    <= c2_day;
      c3_doe    <= c2_doe;
      c3_yr     <= yr3;
      c3_yq     <= yq3;
      c3_rsel   <= c2_rsel;
      c3_wstart <= c2_wstart;
      c3_wend   <= c2_wend;
      c3_wneg   <= c2_wneg;
    end
  end

  // ---------------- stage 4: finish year of era, day of March-based year
  logic                          c4_vld;
  logic [cib_pkg::TS_W-1:0]      c4_t;
  cib_pkg::period_t              c4_per;
  logic [cib_pkg::DAY_W-1:0]     c4_day;
  logic [8:0]                    c4_doy;
  logic                          c4_lf;
  logic                          c4_lp;
  logic [cib_pkg::RDAY_W-1:0]    c4_rsel;
  logic [cib_pkg::DAY_W-1:0]     c4_wstart;
  logic [cib_pkg::DAY_W-1:0]     c4_wend;
  logic                          c4_wneg;

  logic [cib_pkg::DOE_W-1:0]     yr4;
  logic [cib_pkg::YOE_W-1:0]     yoe;
  logic [1:0]                    cent;
  logic [cib_pkg::DOE_W-1:0]     doy;

  always_comb begin
    yr4 = c3_yr;
    yoe = c3_yq;
    for (int k = 0; k < 4; k++) begin
      if (yr4 >= (cib_pkg::DAYS_YEAR << (3 - k))) begin
        yr4 = yr4 - (cib_pkg::DAYS_YEAR << (3 - k));
        yoe[3 - k] = 1'b1;
      end
    end
    if (yoe >= 9'd300)      cent = 2'd3;
    else if (yoe >= 9'd200) cent = 2'd2;
    else if (yoe >= 9'd100) cent = 2'd1;
    else                    cent = 2'd0;
    doy = c3_doe - (18'(yoe) * cib_pkg::DAYS_YEAR + 18'(yoe >> 2) - 18'(cent));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4_vld <= 1'b0;
    end else if (adv) begin
      c4_vld <= c3_vld;
    end
    if (adv) begin
      c4_t      <= c3_t;
      c4_per    <= c3_per;
      c4_day    <= c3_day;
      c4_doy    <= doy[8:0];
      c4_lf     <= cib_pkg::leap_yoe(yoe + 9'd1);  // Feb closing this year
      c4_lp     <= cib_pkg::leap_yoe(yoe);         // Feb closing the year before
      c4_rsel   <= c3_rsel;
      c4_wstart <= c3_wstart;
      c4_wend   <= c3_wend;
      c4_wneg   <= c3_wneg;
    end
  end

  // ---------------- stage 5: month, interval day bounds
  logic [10:0]                   pr;
  logic [3:0]                    mp;
  logic [cib_pkg::DAY_W-1:0]     mstart;
  logic [cib_pkg::DAY_W-1:0]     msd;
  logic [cib_pkg::DAY_W-1:0]     med;
  logic                          jan;
  logic [cib_pkg::DAY_W-1:0]     ys;
  logic [cib_pkg::DAY_W-1:0]     ye;
  logic [cib_pkg::DAY_W-1:0]     sday;
  logic [cib_pkg::DAY_W-1:0]     eday;

  always_comb begin
    pr = 11'(c4_doy) * 11'd5 + 11'd2;
    mp = '0;
    for (int k = 0; k < 4; k++) begin
      if (pr >= (cib_pkg::MP_DIV << (3 - k))) begin
        pr = pr - (cib_pkg::MP_DIV << (3 - k));
        mp[3 - k] = 1'b1;
      end
    end
    mstart = c4_day - 22'(c4_doy);  // March 1 of this March-based year
    msd    = mstart + 22'(cib_pkg::month_off(mp));
    med    = msd + 22'(cib_pkg::month_len(mp, c4_lf));
    jan    = mp >= 4'd10;
    ys     = jan ? mstart + cib_pkg::MAR_TO_JAN
                 : mstart - cib_pkg::JAN_TO_MAR - 22'(c4_lp);
    ye     = ys + 22'(cib_pkg::DAYS_YEAR) + 22'(jan ? c4_lf : c4_lp);
    unique case (c4_per)
      cib_pkg::PER_WEEK: begin
        sday = c4_wstart;
        eday = c4_wend;
      end
      cib_pkg::PER_MONTH: begin
        sday = msd;
        eday = med;
      end
      cib_pkg::PER_YEAR: begin
        sday = ys;
        eday = ye;
      end
      default: begin
        sday = '0;
        eday = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (adv) begin
      dout.vld <= c4_vld;
    end
    if (adv) begin
      dout.t    <= c4_t;
      dout.per  <= c4_per;
      dout.rsel <= c4_rsel;
      dout.sday <= sday;
      dout.eday <= eday;
      dout.sneg <= (c4_per == cib_pkg::PER_WEEK) && c4_wneg;
    end
  end

endmodule

`default_nettype wire
